>>> rtl/core/qri_pkg.sv
// Package for the inverse quaternion rotation pipeline.
// Holds the beat types, the intermediate stage types and the fixed-point widths.
// No dependencies.
`timescale 1ns / 1ps

package qri_pkg;

  // Field widths and fixed-point scaling.
  localparam int W_IN      = 16;  // input and output components
  localparam int W_P1      = 32;  // product of two 16-bit components
  localparam int W_TERM    = 33;  // 2w^2-1, cross and dot terms
  localparam int W_P2      = 49;  // component times a 33-bit term
  localparam int W_SUM     = 51;  // sum of three second-level products
  localparam int SUM_SHIFT = 28;  // two Q2.14 factors
  localparam int W_SH      = W_SUM - SUM_SHIFT;

  // One at scale 2^28.
  localparam logic signed [W_TERM-1:0] ONE_Q28 = 33'sd268435456;

  // Input beat: quaternion (Q2.14) and vector.
  typedef struct packed {
    logic signed [W_IN-1:0] quat_x;
    logic signed [W_IN-1:0] quat_y;
    logic signed [W_IN-1:0] quat_z;
    logic signed [W_IN-1:0] quat_w;
    logic signed [W_IN-1:0] vec_x;
    logic signed [W_IN-1:0] vec_y;
    logic signed [W_IN-1:0] vec_z;
  } qri_in_t;

  // Result beat.
  typedef struct packed {
    logic signed [W_IN-1:0] rot_x;
    logic signed [W_IN-1:0] rot_y;
    logic signed [W_IN-1:0] rot_z;
    logic                   clipped;
  } qri_out_t;

  // First-level products of quaternion and vector components.
  typedef struct packed {
    qri_in_t                src;
    logic signed [W_P1-1:0] ww;
    logic signed [W_P1-1:0] yvz;
    logic signed [W_P1-1:0] zvy;
    logic signed [W_P1-1:0] zvx;
    logic signed [W_P1-1:0] xvz;
    logic signed [W_P1-1:0] xvy;
    logic signed [W_P1-1:0] yvx;
    logic signed [W_P1-1:0] xvx;
    logic signed [W_P1-1:0] yvy;
    logic signed [W_P1-1:0] zvz;
  } qri_prod_t;

  // Terms of the rotation formula, passed between the two halves.
  typedef struct packed {
    qri_in_t                  src;
    logic signed [W_TERM-1:0] wfac;
    logic signed [W_TERM-1:0] cx;
    logic signed [W_TERM-1:0] cy;
    logic signed [W_TERM-1:0] cz;
    logic signed [W_TERM-1:0] dot;
  } qri_terms_t;

  // Second-level products, one set per output component.
  typedef struct packed {
    logic signed [W_P2-1:0] pw_x;
    logic signed [W_P2-1:0] pw_y;
    logic signed [W_P2-1:0] pw_z;
    logic signed [W_P2-1:0] pc_x;
    logic signed [W_P2-1:0] pc_y;
    logic signed [W_P2-1:0] pc_z;
    logic signed [W_P2-1:0] pd_x;
    logic signed [W_P2-1:0] pd_y;
    logic signed [W_P2-1:0] pd_z;
  } qri_mix_t;

endpackage

>>> rtl/core/quat_rotate_inverse.sv
// Inverse quaternion rotation of a 3-vector, four register stages.
// Throughput: one beat per cycle; each stage holds one beat and moves on when
// the stage after it is empty or moving, so a stall at the output backs up
// stage by stage. Reset (rst_n low, synchronous) clears all valid bits.
// Depends on qri_pkg, qri_terms and qri_combine.
`timescale 1ns / 1ps

module quat_rotate_inverse import qri_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  qri_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output qri_out_t out_data
);

  logic       mid_valid;
  logic       mid_ready;
  qri_terms_t mid_data;

  // Products and formula terms.
  qri_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  // Scaling, summation and saturation.
  qri_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An empty output stage means nothing upstream can be blocked.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  // A taken output beat frees the whole chain.
  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output is being drained");

  // The clip flag is only raised when some component sits at a limit.
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clipped) |->
      (out_data.rot_x == 16'sh7fff || out_data.rot_x == -16'sh8000 ||
       out_data.rot_y == 16'sh7fff || out_data.rot_y == -16'sh8000 ||
       out_data.rot_z == 16'sh7fff || out_data.rot_z == -16'sh8000))
    else $error("clip flag raised with no component at a limit");

  // Reset empties the output stage.
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present straight after reset");
`endif

endmodule

>>> rtl/core/qri_terms.sv
// First half of the rotation pipeline: component products, then the
// 2w^2-1, cross-product and dot-product terms. Two register stages.
// Depends on qri_pkg.
`timescale 1ns / 1ps

module qri_terms import qri_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  qri_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output qri_terms_t out_data
);

  logic       s1_valid_r;
  logic       s2_valid_r;
  qri_prod_t  prod_r;
  qri_prod_t  prod_nxt;
  qri_terms_t terms_r;
  qri_terms_t terms_nxt;
  logic       adv1;
  logic       adv2;

  // A stage moves on when it is empty or the stage after it moves on.
  assign adv2     = !s2_valid_r || out_ready;
  assign adv1     = !s1_valid_r || adv2;
  assign in_ready = adv1;

  // Stage one: the ten products of 16-bit components.
  always_comb begin
    prod_nxt.src = in_data;
    prod_nxt.ww  = W_P1'(in_data.quat_w) * W_P1'(in_data.quat_w);
    prod_nxt.yvz = W_P1'(in_data.quat_y) * W_P1'(in_data.vec_z);
    prod_nxt.zvy = W_P1'(in_data.quat_z) * W_P1'(in_data.vec_y);
    prod_nxt.zvx = W_P1'(in_data.quat_z) * W_P1'(in_data.vec_x);
    prod_nxt.xvz = W_P1'(in_data.quat_x) * W_P1'(in_data.vec_z);
    prod_nxt.xvy = W_P1'(in_data.quat_x) * W_P1'(in_data.vec_y);
    prod_nxt.yvx = W_P1'(in_data.quat_y) * W_P1'(in_data.vec_x);
    prod_nxt.xvx = W_P1'(in_data.quat_x) * W_P1'(in_data.vec_x);
    prod_nxt.yvy = W_P1'(in_data.quat_y) * W_P1'(in_data.vec_y);
    prod_nxt.zvz = W_P1'(in_data.quat_z) * W_P1'(in_data.vec_z);
  end

  // Stage two: scalar factor, cross product and dot product.
  always_comb begin
    terms_nxt.src  = prod_r.src;
    terms_nxt.wfac = (W_TERM'(prod_r.ww) <<< 1) - ONE_Q28;
    terms_nxt.cx   = W_TERM'(prod_r.yvz) - W_TERM'(prod_r.zvy);
    terms_nxt.cy   = W_TERM'(prod_r.zvx) - W_TERM'(prod_r.xvz);
    terms_nxt.cz   = W_TERM'(prod_r.xvy) - W_TERM'(prod_r.yvx);
    terms_nxt.dot  = W_TERM'(prod_r.xvx) + W_TERM'(prod_r.yvy) + W_TERM'(prod_r.zvz);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_valid;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers load only when a beat moves in.
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      prod_r <= prod_nxt;
    end
    if (adv2 && s1_valid_r) begin
      terms_r <= terms_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = terms_r;

endmodule

>>> rtl/core/qri_combine.sv
// Second half of the rotation pipeline: scales the terms by the vector and
// quaternion components, sums, shifts by 28 and saturates. Two register stages.
// Depends on qri_pkg.
`timescale 1ns / 1ps

module qri_combine import qri_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  qri_terms_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output qri_out_t   out_data
);

  logic                    s3_valid_r;
  logic                    s4_valid_r;
  qri_mix_t                mix_r;
  qri_mix_t                mix_nxt;
  qri_out_t                res_r;
  qri_out_t                res_nxt;
  logic                    adv3;
  logic                    adv4;
  logic signed [W_SUM-1:0] sum_x;
  logic signed [W_SUM-1:0] sum_y;
  logic signed [W_SUM-1:0] sum_z;
  logic                    hit_x;
  logic                    hit_y;
  logic                    hit_z;

  // Shift right by 28 (floor) and clamp to 16 bits; hit marks a clamp.
  function automatic logic signed [W_IN-1:0] sat_shift(
    input  logic signed [W_SUM-1:0] sum,
    output logic                    hit
  );
    logic signed [W_SH-1:0] sh;
    sh  = sum[W_SUM-1:SUM_SHIFT];
    hit = (sh[W_SH-1:W_IN-1] != '0) && (sh[W_SH-1:W_IN-1] != '1);
    if (!hit) begin
      sat_shift = sh[W_IN-1:0];
    end else if (sh[W_SH-1]) begin
      sat_shift = {1'b1, {(W_IN-1){1'b0}}};
    end else begin
      sat_shift = {1'b0, {(W_IN-1){1'b1}}};
    end
  endfunction

  assign adv4     = !s4_valid_r || out_ready;
  assign adv3     = !s3_valid_r || adv4;
  assign in_ready = adv3;

  // Stage three: nine products of a component and a term.
  always_comb begin
    mix_nxt.pw_x = W_P2'(in_data.src.vec_x)  * W_P2'(in_data.wfac);
    mix_nxt.pw_y = W_P2'(in_data.src.vec_y)  * W_P2'(in_data.wfac);
    mix_nxt.pw_z = W_P2'(in_data.src.vec_z)  * W_P2'(in_data.wfac);
    mix_nxt.pc_x = W_P2'(in_data.src.quat_w) * W_P2'(in_data.cx);
    mix_nxt.pc_y = W_P2'(in_data.src.quat_w) * W_P2'(in_data.cy);
    mix_nxt.pc_z = W_P2'(in_data.src.quat_w) * W_P2'(in_data.cz);
    mix_nxt.pd_x = W_P2'(in_data.src.quat_x) * W_P2'(in_data.dot);
    mix_nxt.pd_y = W_P2'(in_data.src.quat_y) * W_P2'(in_data.dot);
    mix_nxt.pd_z = W_P2'(in_data.src.quat_z) * W_P2'(in_data.dot);
  end

  // Stage four: v*wfac - 2w*(q x v) + 2q*(q . v), then shift and clamp.
  always_comb begin
    sum_x = W_SUM'(mix_r.pw_x) - (W_SUM'(mix_r.pc_x) <<< 1) + (W_SUM'(mix_r.pd_x) <<< 1);
    sum_y = W_SUM'(mix_r.pw_y) - (W_SUM'(mix_r.pc_y) <<< 1) + (W_SUM'(mix_r.pd_y) <<< 1);
    sum_z = W_SUM'(mix_r.pw_z) - (W_SUM'(mix_r.pc_z) <<< 1) + (W_SUM'(mix_r.pd_z) <<< 1);
    res_nxt.rot_x   = sat_shift(sum_x, hit_x);
    res_nxt.rot_y   = sat_shift(sum_y, hit_y);
    res_nxt.rot_z   = sat_shift(sum_z, hit_z);
    res_nxt.clipped = hit_x || hit_y || hit_z;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (adv3) begin
        s3_valid_r <= in_valid;
      end
      if (adv4) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv3 && in_valid) begin
      mix_r <= mix_nxt;
    end
    if (adv4 && s3_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_data  = res_r;

endmodule

>>> tb/tb_quat_rotate_inverse.sv
// Self-checking testbench for the inverse quaternion rotation pipeline.
// Drives directed and random beats under several idle and stall patterns, and
// compares every result beat with a local prediction. Depends on qri_pkg and quat_rotate_inverse.
`timescale 1ns / 1ps

module tb_quat_rotate_inverse import qri_pkg::*;;

  localparam int HALF_PERIOD = 6;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  qri_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  qri_out_t out_data;

  // Rotated vectors still owed by the block, oldest first.
  qri_out_t expected_rot[$];
  qri_out_t want_rot;
  int       fail_count = 0;

  // Idle percentages for the sender and the receiver, set per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Count of requested long hold-offs; the receiver keeps its own copy.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_count = 0;

  quat_rotate_inverse i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Saturates one component to 16 bits and notes whether it clipped.
  function automatic logic signed [W_IN-1:0] clamp_component(input longint v,
                                                             inout bit hit);
    if (v > 32767) begin
      hit = 1'b1;
      return 16'sh7FFF;
    end else if (v < -32768) begin
      hit = 1'b1;
      return 16'sh8000;
    end
    return v[W_IN-1:0];
  endfunction

  // Rotates the vector by the inverse quaternion with exact products.
  function automatic qri_out_t rotate_inverse(input qri_in_t b);
    longint   qx, qy, qz, qw, vx, vy, vz;
    longint   wfac, cx, cy, cz, dot, sx, sy, sz;
    bit       hit;
    qri_out_t r;
    qx = b.quat_x;
    qy = b.quat_y;
    qz = b.quat_z;
    qw = b.quat_w;
    vx = b.vec_x;
    vy = b.vec_y;
    vz = b.vec_z;
    hit = 1'b0;
    wfac = 2 * qw * qw - (longint'(1) <<< SUM_SHIFT);
    cx = qy * vz - qz * vy;
    cy = qz * vx - qx * vz;
    cz = qx * vy - qy * vx;
    dot = qx * vx + qy * vy + qz * vz;
    sx = vx * wfac - 2 * qw * cx + 2 * qx * dot;
    sy = vy * wfac - 2 * qw * cy + 2 * qy * dot;
    sz = vz * wfac - 2 * qw * cz + 2 * qz * dot;
    // Arithmetic shift of a signed value rounds towards minus infinity.
    r.rot_x = clamp_component(sx >>> SUM_SHIFT, hit);
    r.rot_y = clamp_component(sy >>> SUM_SHIFT, hit);
    r.rot_z = clamp_component(sz >>> SUM_SHIFT, hit);
    r.clipped = hit;
    return r;
  endfunction

  function automatic qri_in_t make_beat(input int qx, input int qy, input int qz,
                                        input int qw, input int vx, input int vy,
                                        input int vz);
    qri_in_t b;
    b.quat_x = qx[W_IN-1:0];
    b.quat_y = qy[W_IN-1:0];
    b.quat_z = qz[W_IN-1:0];
    b.quat_w = qw[W_IN-1:0];
    b.vec_x = vx[W_IN-1:0];
    b.vec_y = vy[W_IN-1:0];
    b.vec_z = vz[W_IN-1:0];
    return b;
  endfunction

  function automatic int rand_range_signed(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Fully random bit pattern for every field.
  function automatic qri_in_t raw_beat();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(qri_in_t)-1:0];
  endfunction

  // Random beat: full random patterns, bounded quaternions, or tiny vectors
  // that mostly exercise the rounding of the final shift.
  function automatic qri_in_t random_beat();
    qri_in_t b;
    int      kind;
    kind = $urandom_range(99, 0);
    b = raw_beat();
    if (kind < 40) begin
      b.quat_x = W_IN'(rand_range_signed(-11585, 11585));
      b.quat_y = W_IN'(rand_range_signed(-11585, 11585));
      b.quat_z = W_IN'(rand_range_signed(-11585, 11585));
      b.quat_w = W_IN'(rand_range_signed(-16384, 16384));
    end else if (kind < 60) begin
      b.vec_x = W_IN'(rand_range_signed(-8, 8));
      b.vec_y = W_IN'(rand_range_signed(-8, 8));
      b.vec_z = W_IN'(rand_range_signed(-8, 8));
    end
    return b;
  endfunction

  // Sends one beat, idling at random first, and books its expected result.
  task automatic send_beat(input qri_in_t b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data <= raw_beat();
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    expected_rot.push_back(rotate_inverse(b));
  endtask

  // Lowers valid and waits for every booked result to come out.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_rot.size() == 0);
  endtask

  // Zero, full-scale and identity cases across the field extremes.
  task automatic test_extremes();
    send_beat(make_beat(0, 0, 0, 0, 0, 0, 0));
    send_beat(make_beat(0, 0, 0, 16384, 32767, -32768, 1));
    send_beat(make_beat(0, 0, 0, -16384, -32768, 32767, -1));
    send_beat(make_beat(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_beat(make_beat(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_beat(make_beat(32767, -32768, 32767, -32768, -32768, 32767, -32768));
    send_beat(make_beat(-32768, 0, 0, 0, 32767, 32767, 32767));
    send_beat(make_beat(16384, 0, 0, 0, 1000, -2000, 3000));
    send_beat(make_beat(0, 16384, 0, 0, 1000, -2000, 3000));
    send_beat(make_beat(0, 0, 16384, 0, 1000, -2000, 3000));
    send_beat(make_beat(0, 0, 11585, 11585, 20000, 0, 0));
    wait_drain();
  endtask

  // Non-unit quaternions, saturation on each component, and rounding of
  // small negative sums towards minus infinity.
  task automatic test_special_cases();
    send_beat(make_beat(0, 0, 0, 23170, 100, -100, 7));
    send_beat(make_beat(0, 0, 0, 32767, 30000, 0, 0));
    send_beat(make_beat(0, 0, 0, 32767, 0, -30000, 0));
    send_beat(make_beat(0, 0, 0, 32767, 0, 0, 30000));
    send_beat(make_beat(8192, 8192, 8192, 8192, 3, -5, 7));
    send_beat(make_beat(0, 0, 0, 16383, -1, -1, -1));
    send_beat(make_beat(0, 0, 0, 16383, 1, 1, 1));
    send_beat(make_beat(1, 0, 0, 16384, -1, 0, 1));
    send_beat(make_beat(0, 0, 0, 11586, -3, 2, -7));
    send_beat(make_beat(5000, -7000, 9000, 11000, -1, 1, -1));
    send_beat(make_beat(0, 0, 0, 1, 32767, -32768, 32767));
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the
  // pipeline fills and stalls its input; then the sender waits for a full drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req = hold_req + 1;
    repeat (30) send_beat(random_beat());
    wait_drain();
    repeat (20) send_beat(random_beat());
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) send_beat(random_beat());
    wait_drain();
  endtask

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_count = HOLD_CYCLES;
    end
    if (hold_count > 0) begin
      hold_count = hold_count - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Result checker: every accepted beat must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rot.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        fail_count++;
      end else begin
        want_rot = expected_rot.pop_front();
        if (out_data.rot_x !== want_rot.rot_x) begin
          $error("rot_x: expected %0d, actual %0d", want_rot.rot_x, out_data.rot_x);
          fail_count++;
        end
        if (out_data.rot_y !== want_rot.rot_y) begin
          $error("rot_y: expected %0d, actual %0d", want_rot.rot_y, out_data.rot_y);
          fail_count++;
        end
        if (out_data.rot_z !== want_rot.rot_z) begin
          $error("rot_z: expected %0d, actual %0d", want_rot.rot_z, out_data.rot_z);
          fail_count++;
        end
        if (out_data.clipped !== want_rot.clipped) begin
          $error("clipped: expected %0b, actual %0b", want_rot.clipped, out_data.clipped);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    recv_stall_pct = 58;
    test_special_cases();
    test_backpressure();
    test_random_traffic(270, 0, 0);
    test_random_traffic(270, 58, 0);
    test_random_traffic(270, 0, 58);
    test_random_traffic(270, 22, 22);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
